// ----- sv/bf3_pkg.sv -----
// ----------------------------------------------------------------------------
// bf3_pkg
// Shared constants and types of the 3x3 rgb box filter.
// ----------------------------------------------------------------------------
package bf3_pkg;

  localparam int MAX_WIDTH = 4096;
  localparam int DIM_LIMIT = 4096;
  localparam int MEM_DEPTH = (MAX_WIDTH < DIM_LIMIT) ? MAX_WIDTH : DIM_LIMIT;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam int PIX_W   = 24;
  localparam int CHAN_W  = 8;
  localparam int COORD_W = 12;
  localparam int DIM_W   = 13;
  localparam int SUM_W   = 12;

  localparam logic [DIM_W-1:0] DIM_MIN      = 13'd3;
  localparam logic [DIM_W-1:0] WIDTH_LIMIT  = DIM_W'(MEM_DEPTH);
  localparam logic [DIM_W-1:0] HEIGHT_LIMIT = DIM_W'(DIM_LIMIT);
  localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd480;

  // register index taken from paddr[2]
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [COORD_W-1:0] w_last;
    logic [COORD_W-1:0] h_last;
  } bf3_dims_t;

  typedef struct packed {
    logic [SUM_W-1:0]   sum_red;
    logic [SUM_W-1:0]   sum_green;
    logic [SUM_W-1:0]   sum_blue;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               done;
  } bf3_job_t;

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } bf3_qstat_t;

endpackage

// ----- sv/box_filter_3x3_rgb_core.sv -----
// ----------------------------------------------------------------------------
// box_filter_3x3_rgb_core
// 3x3 mean filter over an rgb raster stream with register access.
//
//   channel   signals                         direction
//   config    psel penable pwrite paddr ...   apb slave, 2 regs at 0x0, 0x4
//   pixels    push full pixel_rgb             in, queue write side
//   results   empty pop mean_* centre_* ...   out, queue read side
//
// one pixel per cycle sustained while full is low; the line memory is read
// when a pixel is taken and written back in the next cycle, one port each.
// a result passes read stage, queue, sums register and output buffer.
// full rises while the queue, counting the pixel in the read stage, is taken up.
// rst clears counters and queues; the line memory needs no clearing since
// every entry is rewritten in a frame before it reaches a result.
// ----------------------------------------------------------------------------
module box_filter_3x3_rgb_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          push,
  input  logic [bf3_pkg::PIX_W-1:0]     pixel_rgb,
  output logic                          full,
  output logic                          empty,
  input  logic                          pop,
  output logic [bf3_pkg::CHAN_W-1:0]    mean_red,
  output logic [bf3_pkg::CHAN_W-1:0]    mean_green,
  output logic [bf3_pkg::CHAN_W-1:0]    mean_blue,
  output logic [bf3_pkg::COORD_W-1:0]   centre_column,
  output logic [bf3_pkg::COORD_W-1:0]   centre_row,
  output logic                          frame_done
);

  localparam int DW = bf3_pkg::DIM_W;
  localparam int KW = bf3_pkg::COORD_W;

  logic [DW-1:0]       frame_width;
  logic [DW-1:0]       frame_height;
  bf3_pkg::bf3_dims_t  dims;
  logic                cfg_wr;

  logic                job_valid;
  bf3_pkg::bf3_job_t   job;
  bf3_pkg::bf3_job_t   head;
  bf3_pkg::bf3_qstat_t qstat;
  logic                qpop;

  // clamped size, stored as index of the last column or row
  function automatic logic [KW-1:0] dim_last(
    input logic [DW-1:0] v,
    input logic [DW-1:0] lim
  );
    logic [DW-1:0] e;
    if (v < bf3_pkg::DIM_MIN) begin
      e = bf3_pkg::DIM_MIN;
    end else if (v > lim) begin
      e = lim;
    end else begin
      e = v;
    end
    return KW'(e - 1'b1);
  endfunction

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bf3_pkg::RESET_WIDTH;
      frame_height <= bf3_pkg::RESET_HEIGHT;
      dims.w_last  <= dim_last(bf3_pkg::RESET_WIDTH, bf3_pkg::WIDTH_LIMIT);
      dims.h_last  <= dim_last(bf3_pkg::RESET_HEIGHT, bf3_pkg::HEIGHT_LIMIT);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        bf3_pkg::REG_FRAME_WIDTH: begin
          frame_width <= pwdata[DW-1:0];
          dims.w_last <= dim_last(pwdata[DW-1:0], bf3_pkg::WIDTH_LIMIT);
        end
        bf3_pkg::REG_FRAME_HEIGHT: begin
          frame_height <= pwdata[DW-1:0];
          dims.h_last  <= dim_last(pwdata[DW-1:0], bf3_pkg::HEIGHT_LIMIT);
        end
        default: begin
          frame_width <= frame_width;
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      bf3_pkg::REG_FRAME_WIDTH:  prdata = 32'(frame_width);
      bf3_pkg::REG_FRAME_HEIGHT: prdata = 32'(frame_height);
      default:                   prdata = '0;
    endcase
  end

  bf3_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pixel_rgb (pixel_rgb),
    .full      (full),
    .cfg_clear (cfg_wr),
    .dims      (dims),
    .qstat     (qstat),
    .job_valid (job_valid),
    .job       (job)
  );

  bf3_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_valid),
    .push_data (job),
    .pop       (qpop),
    .head      (head),
    .stat      (qstat)
  );

  bf3_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .qstat         (qstat),
    .qpop          (qpop),
    .empty         (empty),
    .pop           (pop),
    .mean_red      (mean_red),
    .mean_green    (mean_green),
    .mean_blue     (mean_blue),
    .centre_column (centre_column),
    .centre_row    (centre_row),
    .frame_done    (frame_done)
  );

endmodule

// ----- sv/bf3_queue.sv -----
// ----------------------------------------------------------------------------
// bf3_queue
// Short queue of window sums between the front and the back.
// ----------------------------------------------------------------------------
module bf3_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bf3_pkg::bf3_job_t   push_data,
  input  logic                pop,
  output bf3_pkg::bf3_job_t   head,
  output bf3_pkg::bf3_qstat_t stat
);

  bf3_pkg::bf3_job_t                entries [bf3_pkg::QDEPTH];
  logic [bf3_pkg::QPTR_W-1:0]       wr_ptr;
  logic [bf3_pkg::QPTR_W-1:0]       rd_ptr;
  logic [bf3_pkg::QCNT_W-1:0]       count;

  function automatic logic [bf3_pkg::QPTR_W-1:0] ptr_inc(
    input logic [bf3_pkg::QPTR_W-1:0] p
  );
    if (p == bf3_pkg::QPTR_W'(bf3_pkg::QDEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      priority if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head       = entries[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.count = count;

endmodule

// ----- sv/bf3_front.sv -----
// ----------------------------------------------------------------------------
// bf3_front
// Raster counters, line memory and column-sum window; emits nine-pixel sums
// for interior centres into the queue.
// ----------------------------------------------------------------------------
module bf3_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  logic [bf3_pkg::PIX_W-1:0]        pixel_rgb,
  output logic                             full,
  input  logic                             cfg_clear,
  input  bf3_pkg::bf3_dims_t               dims,
  input  bf3_pkg::bf3_qstat_t              qstat,
  output logic                             job_valid,
  output bf3_pkg::bf3_job_t                job
);

  localparam int PW = bf3_pkg::PIX_W;
  localparam int CW = bf3_pkg::CHAN_W;
  localparam int AW = bf3_pkg::ADDR_W;
  localparam int KW = bf3_pkg::COORD_W;
  localparam int SW = bf3_pkg::SUM_W;
  localparam int COL_W = CW + 2;

  typedef struct packed {
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
  } colsum_t;

  // {row y-2, row y-1} per column
  logic [2*PW-1:0] line_mem [bf3_pkg::MEM_DEPTH];
  logic [2*PW-1:0] rd_data;

  logic [KW-1:0] col_count;
  logic [KW-1:0] row_count;
  logic          accept;
  logic [bf3_pkg::QCNT_W:0] occupancy;

  logic          f1_valid;
  logic [PW-1:0] f1_px;
  logic [AW-1:0] f1_addr;
  logic          f1_emit;
  logic [KW-1:0] f1_col;
  logic [KW-1:0] f1_row;
  logic          f1_done;

  logic [PW-1:0] top;
  logic [PW-1:0] mid;
  colsum_t       cur;
  colsum_t       win0;
  colsum_t       win1;

  function automatic logic [COL_W-1:0] add3(
    input logic [CW-1:0] a,
    input logic [CW-1:0] b,
    input logic [CW-1:0] c
  );
    return COL_W'(a) + COL_W'(b) + COL_W'(c);
  endfunction

  function automatic logic [SW-1:0] add3w(
    input logic [COL_W-1:0] a,
    input logic [COL_W-1:0] b,
    input logic [COL_W-1:0] c
  );
    return SW'(a) + SW'(b) + SW'(c);
  endfunction

  // room counted for the item still in the read stage
  assign occupancy = {1'b0, qstat.count} + (bf3_pkg::QCNT_W + 1)'(f1_valid);
  assign full      = (occupancy >= (bf3_pkg::QCNT_W + 1)'(bf3_pkg::QDEPTH));
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= line_mem[col_count[AW-1:0]];
    end
    if (f1_valid) begin
      line_mem[f1_addr] <= {mid, f1_px};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      f1_valid  <= 1'b0;
    end else begin
      f1_valid <= accept;
      if (cfg_clear) begin
        col_count <= '0;
        row_count <= '0;
      end else if (accept) begin
        if (col_count == dims.w_last) begin
          col_count <= '0;
          row_count <= (row_count == dims.h_last) ? '0 : row_count + 1'b1;
        end else begin
          col_count <= col_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_px   <= pixel_rgb;
      f1_addr <= col_count[AW-1:0];
      f1_emit <= (col_count >= KW'(2)) && (row_count >= KW'(2));
      f1_col  <= col_count - 1'b1;
      f1_row  <= row_count - 1'b1;
      f1_done <= (col_count == dims.w_last) && (row_count == dims.h_last);
    end
    if (f1_valid) begin
      win0 <= win1;
      win1 <= cur;
    end
  end

  assign top = rd_data[2*PW-1:PW];
  assign mid = rd_data[PW-1:0];

  assign cur.red   = add3(top[3*CW-1:2*CW], mid[3*CW-1:2*CW], f1_px[3*CW-1:2*CW]);
  assign cur.green = add3(top[2*CW-1:CW], mid[2*CW-1:CW], f1_px[2*CW-1:CW]);
  assign cur.blue  = add3(top[CW-1:0], mid[CW-1:0], f1_px[CW-1:0]);

  assign job_valid     = f1_valid && f1_emit;
  assign job.sum_red   = add3w(win0.red, win1.red, cur.red);
  assign job.sum_green = add3w(win0.green, win1.green, cur.green);
  assign job.sum_blue  = add3w(win0.blue, win1.blue, cur.blue);
  assign job.col       = f1_col;
  assign job.row       = f1_row;
  assign job.done      = f1_done;

endmodule

// ----- sv/bf3_back.sv -----
// ----------------------------------------------------------------------------
// bf3_back
// Divides the nine-pixel sums by nine and holds results for the consumer.
// ----------------------------------------------------------------------------
module bf3_back (
  input  logic                          clk,
  input  logic                          rst,
  input  bf3_pkg::bf3_job_t             head,
  input  bf3_pkg::bf3_qstat_t           qstat,
  output logic                          qpop,
  output logic                          empty,
  input  logic                          pop,
  output logic [bf3_pkg::CHAN_W-1:0]    mean_red,
  output logic [bf3_pkg::CHAN_W-1:0]    mean_green,
  output logic [bf3_pkg::CHAN_W-1:0]    mean_blue,
  output logic [bf3_pkg::COORD_W-1:0]   centre_column,
  output logic [bf3_pkg::COORD_W-1:0]   centre_row,
  output logic                          frame_done
);

  localparam int CW = bf3_pkg::CHAN_W;
  localparam int KW = bf3_pkg::COORD_W;
  localparam int SW = bf3_pkg::SUM_W;
  localparam int PROD_W = 2 * SW;
  // floor(s/9) == (s * 3641) >> 15 for every nine-pixel sum
  localparam logic [SW-1:0] RECIP_9 = 12'd3641;
  localparam int RECIP_SHIFT = 15;

  typedef struct packed {
    logic [CW-1:0] red;
    logic [CW-1:0] green;
    logic [CW-1:0] blue;
    logic [KW-1:0] col;
    logic [KW-1:0] row;
    logic          done;
  } res_t;

  bf3_pkg::bf3_job_t sums;
  logic              sums_valid;
  logic              sums_load;

  res_t       out_buf [2];
  logic       out_wr_ptr;
  logic       out_rd_ptr;
  logic [1:0] out_count;
  logic       out_pop;
  logic       out_wr;
  res_t       res;

  function automatic logic [CW-1:0] div9(input logic [SW-1:0] s);
    logic [PROD_W-1:0] p;
    p = PROD_W'(s) * PROD_W'(RECIP_9);
    return p[RECIP_SHIFT+CW-1:RECIP_SHIFT];
  endfunction

  assign out_pop   = pop && !empty;
  assign out_wr    = sums_valid && ((out_count != 2'd2) || out_pop);
  assign sums_load = !sums_valid || out_wr;
  assign qpop      = !qstat.empty && sums_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      sums_valid <= 1'b0;
      out_wr_ptr <= 1'b0;
      out_rd_ptr <= 1'b0;
      out_count  <= '0;
    end else begin
      if (sums_load) begin
        sums_valid <= qpop;
      end
      if (out_wr) begin
        out_wr_ptr <= !out_wr_ptr;
      end
      if (out_pop) begin
        out_rd_ptr <= !out_rd_ptr;
      end
      priority if (out_wr && !out_pop) begin
        out_count <= out_count + 1'b1;
      end else if (out_pop && !out_wr) begin
        out_count <= out_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (qpop) begin
      sums <= head;
    end
    if (out_wr) begin
      out_buf[out_wr_ptr] <= res;
    end
  end

  assign res.red   = div9(sums.sum_red);
  assign res.green = div9(sums.sum_green);
  assign res.blue  = div9(sums.sum_blue);
  assign res.col   = sums.col;
  assign res.row   = sums.row;
  assign res.done  = sums.done;

  assign empty         = (out_count == '0);
  assign mean_red      = out_buf[out_rd_ptr].red;
  assign mean_green    = out_buf[out_rd_ptr].green;
  assign mean_blue     = out_buf[out_rd_ptr].blue;
  assign centre_column = out_buf[out_rd_ptr].col;
  assign centre_row    = out_buf[out_rd_ptr].row;
  assign frame_done    = out_buf[out_rd_ptr].done;

endmodule
